/* hdl/sccto_pkg.sv */
`default_nettype none
package sccto_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;

    localparam int CFG_W  = 7;
    localparam int CFG_AW = 1;
    localparam logic [CFG_AW-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_CAND_COUNT = 1'b1;

    localparam int NODE_W = 6;
    localparam int LEN_W  = 7;

    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR,
        S_CNT_RD, S_CNT_A, S_CNT_B,
        S_PFX_RD, S_PFX_WR, S_PFX_END,
        S_SCT_RD, S_SCT_A, S_SCT_B,
        S_ROOT, S_TWAIT, S_PUSH, S_EDGE, S_TGT, S_VIS,
        S_DONE, S_POP_RD, S_POP_WR, S_RET, S_RESTORE,
        S_EM_INIT, S_SEG_RD, S_SEG_ACC, S_SCAN, S_FIN
    } t_state;

    typedef struct packed {
        logic              last;
        logic              edges_dropped;
        logic [LEN_W-1:0]  loop_length;
        logic              in_loop;
        logic [NODE_W-1:0] candidate_index;
    } t_result;

endpackage
`default_nettype wire

/* hdl/scc_topological_destruct_order_unit.sv */
// channel   dir  tdata (low bit up)                        tuser / tlast
// s_axis    in   edge_source[5:0], edge_target[11:6]       tuser[0] command
// m_axis    out  candidate_index[5:0], loop_length[12:6]   tuser[0] in_loop,
//                                                          tuser[1] edges_dropped, tlast
// cfg       in   i_cfg_we, i_cfg_addr (0 node, 1 cand), i_cfg_data[6:0]
//
// An edge request is accepted only while idle. A run sweeps the cursor memory,
// passes the edges twice, builds offsets, walks the nodes and their edges, and
// emits by scanning each loop's index span; all of it is bound by the state memories.
// Synchronous active-low reset clears control state only; memories are rebuilt
// on each run. Input is held off for the whole run; the emit stalls on m_axis.
`default_nettype none
module scc_topological_destruct_order_unit
    import sccto_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_EDGES = DEF_MAX_EDGES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [15:0]       s_axis_tdata,   // edge_source, edge_target
    input  wire logic [0:0]        s_axis_tuser,   // command
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [15:0]            m_axis_tdata,   // candidate_index, loop_length
    output logic [1:0]             m_axis_tuser,   // in_loop, edges_dropped
    output logic                   m_axis_tlast
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int FW  = 3 * NW + 2 * ECW;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_cfg_n, r_cfg_c;
    logic [NCW-1:0]   r_n, r_c;
    logic [ECW-1:0]   r_etot, r_e, r_sum;
    logic             r_ovf;
    logic [NCW-1:0]   r_v, r_r, r_cnt, r_fd, r_pd, r_base, r_cbase, r_j, r_emit, r_len;
    logic [NW-1:0]    r_s, r_t, r_x, r_i, r_max, r_min;
    logic [NW-1:0]    r_top_node, r_top_low, r_top_vis;
    logic [ECW-1:0]   r_top_next, r_top_end;
    logic [MAX_NODES-1:0] r_visited, r_assigned, r_sel;

    // memories
    logic [11:0]    m_raw  [MAX_EDGES];
    logic [ECW-1:0] m_cur  [MAX_NODES];
    logic [ECW-1:0] m_off  [MAX_NODES+1];
    logic [NW-1:0]  m_srt  [MAX_EDGES];
    logic [NW-1:0]  m_vo   [MAX_NODES];
    logic [FW-1:0]  m_frm  [MAX_NODES];
    logic [NW-1:0]  m_pst  [MAX_NODES];
    logic [NW:0]    m_mem  [MAX_NODES];

    logic [11:0]    r_raw_q;
    logic [ECW-1:0] r_cur_q, r_offa_q, r_offb_q;
    logic [NW-1:0]  r_srt_q, r_vo_q, r_pst_q;
    logic [FW-1:0]  r_frm_q;
    logic [NW:0]    r_mem_q;

    // clamped configuration
    logic [CFG_W-1:0] cl_n, cl_c;
    always_comb begin
        cl_n = r_cfg_n;
        if (r_cfg_n == '0) cl_n = CFG_W'(1);
        if (r_cfg_n > CFG_W'(MAX_NODES)) cl_n = CFG_W'(MAX_NODES);
        cl_c = r_cfg_c;
        if (r_cfg_c == '0) cl_c = CFG_W'(1);
        if (r_cfg_c > cl_n) cl_c = cl_n;
    end

    logic in_acc, in_cmd;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_cmd = s_axis_tuser[0];

    // shared decisions
    logic [5:0]     raw_src, raw_tgt;
    logic           raw_ok, e_last, v_last, edge_more, pop_match;
    logic [ECW-1:0] e_nxt;
    logic [NCW-1:0] v_nxt;
    logic [NW-1:0]  mem_m, acc_max, acc_min;
    logic           mem_f, acc_hit, scan_hit, scan_end, out_free, out_load;
    logic [NCW-1:0] acc_len;
    logic [NW-1:0]  f_node, f_low, f_vis;
    logic [ECW-1:0] f_next, f_end;

    assign raw_src   = r_raw_q[5:0];
    assign raw_tgt   = r_raw_q[11:6];
    assign raw_ok    = ({1'b0, raw_src} < 7'(r_n)) && ({1'b0, raw_tgt} < 7'(r_n));
    assign e_nxt     = r_e + ECW'(1);
    assign e_last    = (e_nxt == r_etot);
    assign v_nxt     = r_v + NCW'(1);
    assign v_last    = (v_nxt == r_n);
    assign edge_more = (r_top_next < r_top_end);
    assign pop_match = (r_pst_q == r_top_node);
    assign mem_m     = r_mem_q[NW-1:0];
    assign mem_f     = r_mem_q[NW];
    assign acc_hit   = (NCW'(mem_m) < r_c);
    assign acc_len   = r_len + NCW'(acc_hit);
    assign acc_max   = (acc_hit && mem_m > r_max) ? mem_m : r_max;
    assign acc_min   = (acc_hit && mem_m < r_min) ? mem_m : r_min;
    assign scan_hit  = r_sel[r_i];
    assign scan_end  = (r_i == r_min);
    assign out_load  = (r_state == S_SCAN) && scan_hit && out_free;
    assign {f_node, f_next, f_end, f_low, f_vis} = r_frm_q;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_acc && in_cmd == CMD_RUN) n_state = S_CLR;
            S_CLR:     if (v_last) n_state = (r_etot == '0) ? S_PFX_RD : S_CNT_RD;
            S_CNT_RD:  n_state = S_CNT_A;
            S_CNT_A:   n_state = raw_ok ? S_CNT_B : (e_last ? S_PFX_RD : S_CNT_RD);
            S_CNT_B:   n_state = e_last ? S_PFX_RD : S_CNT_RD;
            S_PFX_RD:  n_state = S_PFX_WR;
            S_PFX_WR:  n_state = v_last ? S_PFX_END : S_PFX_RD;
            S_PFX_END: n_state = (r_etot == '0) ? S_ROOT : S_SCT_RD;
            S_SCT_RD:  n_state = S_SCT_A;
            S_SCT_A:   n_state = raw_ok ? S_SCT_B : (e_last ? S_ROOT : S_SCT_RD);
            S_SCT_B:   n_state = e_last ? S_ROOT : S_SCT_RD;
            S_ROOT: begin
                if (r_r == r_c) n_state = S_EM_INIT;
                else if (!r_visited[r_r[NW-1:0]]) n_state = S_TWAIT;
            end
            S_TWAIT:   n_state = r_visited[r_x] ? S_VIS : S_PUSH;
            S_PUSH:    n_state = S_EDGE;
            S_EDGE:    n_state = edge_more ? S_TGT : S_DONE;
            S_TGT:     n_state = S_TWAIT;
            S_VIS:     n_state = S_EDGE;
            S_DONE:    n_state = (r_top_low == r_top_vis) ? S_POP_RD : S_RET;
            S_POP_RD:  n_state = S_POP_WR;
            S_POP_WR:  n_state = pop_match ? S_RET : S_POP_RD;
            S_RET:     n_state = (r_fd > NCW'(1)) ? S_RESTORE : S_ROOT;
            S_RESTORE: n_state = S_EDGE;
            S_EM_INIT: n_state = S_SEG_RD;
            S_SEG_RD:  n_state = S_SEG_ACC;
            S_SEG_ACC: begin
                if (mem_f) begin
                    if (acc_len != '0) n_state = S_SCAN;
                    else n_state = (r_j == '0) ? S_FIN : S_SEG_RD;
                end else begin
                    n_state = S_SEG_RD;
                end
            end
            S_SCAN:    if (out_load && scan_end) n_state = (r_j == '0) ? S_FIN : S_SEG_RD;
            S_FIN:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_n <= CFG_W'(1);
            r_cfg_c <= CFG_W'(1);
            r_etot  <= '0;
            r_ovf   <= 1'b0;
            r_sel   <= '0;
        end else begin
            if (i_cfg_we && i_cfg_addr == CFG_NODE_COUNT) r_cfg_n <= i_cfg_data;
            if (i_cfg_we && i_cfg_addr == CFG_CAND_COUNT) r_cfg_c <= i_cfg_data;
            if (in_acc && in_cmd == CMD_ADD) begin
                if (r_etot == ECW'(MAX_EDGES)) r_ovf <= 1'b1;
                else r_etot <= r_etot + ECW'(1);
            end
            if ((r_state == S_CNT_A) && !raw_ok) r_ovf <= 1'b1;
            if (r_state == S_FIN) begin
                r_etot <= '0;
                r_ovf  <= 1'b0;
            end
            if (r_state == S_SEG_ACC && acc_hit) r_sel[mem_m] <= 1'b1;
            if (out_load) r_sel[r_i] <= 1'b0;
        end
    end

    // walk and emit datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n       <= NCW'(cl_n);
                r_c       <= NCW'(cl_c);
                r_v       <= '0;
                r_r       <= '0;
                r_cnt     <= '0;
                r_fd      <= '0;
                r_pd      <= '0;
                r_base    <= '0;
                r_cbase   <= '0;
                r_emit    <= '0;
                r_sum     <= '0;
                r_visited <= '0;
                r_assigned <= '0;
            end
            S_CLR: begin
                r_v <= v_last ? '0 : v_nxt;
                r_e <= '0;
            end
            S_CNT_A, S_SCT_A: begin
                r_s <= raw_src[NW-1:0];
                r_t <= raw_tgt[NW-1:0];
                if (!raw_ok) r_e <= e_nxt;
            end
            S_CNT_B, S_SCT_B: r_e <= e_nxt;
            S_PFX_WR: begin
                r_sum <= r_sum + r_cur_q;
                r_v   <= v_nxt;
            end
            S_PFX_END: r_e <= '0;
            S_ROOT: begin
                r_x <= r_r[NW-1:0];
                if (r_r != r_c && r_visited[r_r[NW-1:0]]) r_r <= r_r + NCW'(1);
            end
            S_PUSH: begin
                r_visited[r_x] <= 1'b1;
                r_top_node <= r_x;
                r_top_next <= r_offa_q;
                r_top_end  <= r_offb_q;
                r_top_low  <= NW'(r_cnt);
                r_top_vis  <= NW'(r_cnt);
                r_cnt      <= r_cnt + NCW'(1);
                r_pd       <= r_pd + NCW'(1);
                r_fd       <= r_fd + NCW'(1);
            end
            S_EDGE: if (edge_more) r_top_next <= r_top_next + ECW'(1);
            S_TGT: r_x <= r_srt_q;
            S_VIS: begin
                if (!r_assigned[r_x] && r_vo_q < r_top_low) r_top_low <= r_vo_q;
            end
            S_POP_RD: r_pd <= r_pd - NCW'(1);
            S_POP_WR: begin
                r_assigned[r_pst_q] <= 1'b1;
                r_base <= r_base + NCW'(1);
                if (pop_match) r_cbase <= r_base + NCW'(1);
            end
            S_RET: begin
                r_fd <= r_fd - NCW'(1);
                if (r_fd <= NCW'(1)) r_r <= r_r + NCW'(1);
            end
            S_RESTORE: begin
                r_top_node <= f_node;
                r_top_next <= f_next;
                r_top_end  <= f_end;
                r_top_vis  <= f_vis;
                r_top_low  <= (r_top_low < f_low) ? r_top_low : f_low;
            end
            S_EM_INIT: begin
                r_j   <= r_base;
                r_len <= '0;
                r_max <= '0;
                r_min <= '1;
            end
            S_SEG_RD: r_j <= r_j - NCW'(1);
            S_SEG_ACC: begin
                r_len <= acc_len;
                r_max <= acc_max;
                r_min <= acc_min;
                r_i   <= acc_max;
            end
            S_SCAN: begin
                if (out_load) begin
                    r_emit <= r_emit + NCW'(1);
                    if (scan_end) begin
                        r_len <= '0;
                        r_max <= '0;
                        r_min <= '1;
                    end else begin
                        r_i <= r_i - NW'(1);
                    end
                end else if (!scan_hit) begin
                    r_i <= r_i - NW'(1);
                end
            end
            default: ;
        endcase
    end

    // raw edge store
    always_ff @(posedge i_clk) begin
        if (in_acc && in_cmd == CMD_ADD && r_etot != ECW'(MAX_EDGES))
            m_raw[r_etot[EW-1:0]] <= {s_axis_tdata[11:6], s_axis_tdata[5:0]};
        r_raw_q <= m_raw[r_e[EW-1:0]];
    end

    // per-source cursor
    logic           cur_we;
    logic [NW-1:0]  cur_waddr, cur_raddr;
    logic [ECW-1:0] cur_wdata;
    always_comb begin
        cur_we    = 1'b0;
        cur_waddr = r_v[NW-1:0];
        cur_wdata = '0;
        case (r_state)
            S_CLR: cur_we = 1'b1;
            S_CNT_B, S_SCT_B: begin
                cur_we    = 1'b1;
                cur_waddr = r_s;
                cur_wdata = r_cur_q + ECW'(1);
            end
            S_PFX_WR: begin
                cur_we    = 1'b1;
                cur_wdata = r_sum;
            end
            default: ;
        endcase
        cur_raddr = (r_state == S_CNT_A || r_state == S_SCT_A) ? raw_src[NW-1:0]
                                                                : r_v[NW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (cur_we) m_cur[cur_waddr] <= cur_wdata;
        r_cur_q <= m_cur[cur_raddr];
    end

    // edge offsets, read at a node and the one after it
    always_ff @(posedge i_clk) begin
        if (r_state == S_PFX_WR || r_state == S_PFX_END) m_off[r_v] <= r_sum;
        r_offa_q <= m_off[NCW'(r_x)];
        r_offb_q <= m_off[NCW'(r_x) + NCW'(1)];
    end

    // sorted targets
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCT_B) m_srt[r_cur_q[EW-1:0]] <= r_t;
        r_srt_q <= m_srt[r_top_next[EW-1:0]];
    end

    // visit order
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH) m_vo[r_x] <= NW'(r_cnt);
        r_vo_q <= m_vo[r_x];
    end

    // frames below the cached top
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH && r_fd != '0)
            m_frm[NW'(r_fd - NCW'(1))] <=
                {r_top_node, r_top_next, r_top_end, r_top_low, r_top_vis};
        r_frm_q <= m_frm[NW'(r_fd - NCW'(2))];
    end

    // pending stack
    always_ff @(posedge i_clk) begin
        if (r_state == S_PUSH) m_pst[r_pd[NW-1:0]] <= r_x;
        r_pst_q <= m_pst[NW'(r_pd - NCW'(1))];
    end

    // component members, top bit marks the first of each component
    always_ff @(posedge i_clk) begin
        if (r_state == S_POP_WR) m_mem[r_base[NW-1:0]] <= {(r_base == r_cbase), r_pst_q};
        r_mem_q <= m_mem[NW'(r_j - NCW'(1))];
    end

    t_result out_res, out_q;
    always_comb begin
        out_res.candidate_index = NODE_W'(r_i);
        out_res.in_loop         = (r_len > NCW'(1));
        out_res.loop_length     = LEN_W'(r_len);
        out_res.edges_dropped   = r_ovf;
        out_res.last            = (r_emit == r_c - NCW'(1));
    end

    sccto_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_res    (out_res),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_res    (out_q),
        .o_free   (out_free)
    );

    assign m_axis_tdata = {3'b000, out_q.loop_length, out_q.candidate_index};
    assign m_axis_tuser = {out_q.edges_dropped, out_q.in_loop};
    assign m_axis_tlast = out_q.last;

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_emit < r_c))
        else $error("more candidates emitted than the run holds");

    a_fin_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_etot == '0 && !r_ovf))
        else $error("edge store not cleared after run");

    a_frame_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE) |-> (r_fd != '0))
        else $error("edge step with no frame");

    a_stack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_INIT) |-> (r_pd == '0))
        else $error("pending stack not empty after walk");

    a_first_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEG_ACC && r_j == '0) |-> mem_f)
        else $error("member list does not open a component");

endmodule
`default_nettype wire

/* hdl/sccto_out_reg.sv */
`default_nettype none
module sccto_out_reg
    import sccto_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_tready,
    output logic         o_tvalid,
    output t_result      o_res,
    output logic         o_free
);

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_res    = r_res;
    assign o_free   = !r_valid || i_tready;

endmodule
`default_nettype wire
